/* sv/ptm_pkg.sv */
`default_nettype none

package ptm_pkg;

    localparam int VA_W    = 48;
    localparam int FRAME_W = 40;
    localparam int PA_W    = 52;
    localparam int ENTRY_W = FRAME_W + 1;
    localparam int NFP_W   = 13;
    localparam int IDX_W   = 9;
    localparam int OFF_W   = 12;

    typedef enum logic [1:0] {
        REQ_MAP   = 2'd0,
        REQ_UNMAP = 2'd1,
        REQ_XLATE = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_UNMAPPED = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } walk_state_t;

    typedef struct packed {
        logic [PA_W-1:0] phys_addr;
        logic [1:0]      status;
    } ptm_result_t;

    localparam logic [1:0] LVL_ROOT = 2'd3;
    localparam logic [1:0] LVL_LEAF = 2'd0;

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd3:    idx = va[47:39];
            2'd2:    idx = va[38:30];
            2'd1:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

/* sv/ptm_ram.sv */
`default_nettype none

module ptm_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 32768
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/ptm_walk.sv */
`default_nettype none

module ptm_walk import ptm_pkg::*; #(
    parameter int TABLE_PAGES = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            in_req,
    input  wire logic [VA_W-1:0]                       in_va,
    input  wire logic [FRAME_W-1:0]                    in_frame,
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output ptm_result_t                                res,
    output logic                                       mem_we,
    output logic [$clog2(TABLE_PAGES)+IDX_W-1:0]       mem_waddr,
    output logic [ENTRY_W-1:0]                         mem_wdata,
    output logic [$clog2(TABLE_PAGES)+IDX_W-1:0]       mem_raddr,
    input  wire logic [ENTRY_W-1:0]                    mem_rdata
);

    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int ADDR_W = PAGE_W + IDX_W;
    localparam int DEPTH  = TABLE_PAGES * 512;
    localparam logic [ADDR_W-1:0]  CLR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [NFP_W-1:0]   NFP_LIMIT = NFP_W'(TABLE_PAGES);
    localparam logic [FRAME_W-1:0] PG_LIMIT  = FRAME_W'(TABLE_PAGES);

    walk_state_t          state_reg, state_next;
    logic [1:0]           lvl_reg, lvl_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [VA_W-1:0]      va_reg, va_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [1:0]           req_reg, req_next;
    logic [NFP_W-1:0]     nfp_reg, nfp_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    ptm_result_t          res_reg, res_next;

    logic                 child_ok;
    logic                 full;
    logic [FRAME_W-1:0]   child;
    logic [ADDR_W-1:0]    cur_addr;
    logic [1:0]           lvl_dn;

    assign child    = mem_rdata[ENTRY_W-1:1];
    assign child_ok = mem_rdata[0] && (child < PG_LIMIT);
    assign full     = (nfp_reg >= NFP_LIMIT);
    assign lvl_dn   = lvl_reg - 2'd1;
    assign cur_addr = {page_reg, level_index(va_reg, lvl_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            nfp_reg   <= NFP_W'(1);
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            nfp_reg   <= nfp_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg   <= lvl_next;
        page_reg  <= page_next;
        va_reg    <= va_next;
        frame_reg <= frame_next;
        req_reg   <= req_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        page_next  = page_reg;
        va_next    = va_reg;
        frame_next = frame_reg;
        req_next   = req_reg;
        nfp_next   = nfp_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = cur_addr;
        mem_wdata  = '0;
        mem_raddr  = cur_addr;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready  = 1'b1;
                mem_raddr = {PAGE_W'(0), level_index(in_va, LVL_ROOT)};
                if (in_valid) begin
                    va_next    = in_va;
                    frame_next = in_frame;
                    req_next   = in_req;
                    lvl_next   = LVL_ROOT;
                    page_next  = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                res_next.phys_addr = '0;
                res_next.status    = STAT_UNMAPPED;
                if (lvl_reg != LVL_LEAF) begin
                    if (child_ok) begin
                        page_next = child[PAGE_W-1:0];
                        lvl_next  = lvl_dn;
                        mem_raddr = {child[PAGE_W-1:0], level_index(va_reg, lvl_dn)};
                    end else if (req_reg == REQ_MAP) begin
                        if (full) begin
                            res_next.status = STAT_FULL;
                            state_next      = ST_DONE;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = {(FRAME_W - NFP_W)'(0), nfp_reg, 1'b1};
                            page_next = nfp_reg[PAGE_W-1:0];
                            nfp_next  = nfp_reg + NFP_W'(1);
                            lvl_next  = lvl_dn;
                            mem_raddr = {nfp_reg[PAGE_W-1:0], level_index(va_reg, lvl_dn)};
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    state_next = ST_DONE;
                    case (req_reg)
                        REQ_MAP: begin
                            mem_we          = 1'b1;
                            mem_wdata       = {frame_reg, 1'b1};
                            res_next.status = STAT_OK;
                        end
                        REQ_UNMAP: begin
                            if (mem_rdata[0]) begin
                                mem_we          = 1'b1;
                                res_next.status = STAT_OK;
                            end
                        end
                        REQ_XLATE: begin
                            if (mem_rdata[0]) begin
                                res_next.phys_addr = {child, va_reg[OFF_W-1:0]};
                                res_next.status    = STAT_OK;
                            end
                        end
                        default: begin
                            res_next.status = STAT_UNMAPPED;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* sv/four_level_page_table_manager_unit.sv */
// Channel  Dir  Signals                           Contents
// s_       in   s_tvalid s_tready s_tdata s_tuser  request: address, frame, type
// m_       out  m_tvalid m_tready m_tdata m_tuser  result: physical address, status
//
// After reset a clearing pass writes all TABLE_PAGES*512 table entries to zero
// (32768 at the default), with s_tready low.
// A request is taken in the idle state; the walk then reads one table level per
// step from the table memory, which has separate read and write ports (all four
// levels on a full walk, fewer on a lookup miss or a full table) before hand-over.
// The result register holds a finished transaction while m_tready is low; the
// next request is taken meanwhile and waits at hand-over.
`default_nettype none

module four_level_page_table_manager_unit import ptm_pkg::*; #(
    parameter int TABLE_PAGES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,  // virt_addr[47:0], phys_frame[87:48]
    input  wire logic [1:0]  s_tuser,  // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // phys_addr[51:0], zero pad[55:52]
    output logic [1:0]       m_tuser   // status[1:0]
);

    localparam int ADDR_W = $clog2(TABLE_PAGES) + IDX_W;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;
    logic                res_valid;
    logic                res_ready;
    ptm_result_t         res;

    logic                m_valid_reg, m_valid_next;
    ptm_result_t         m_data_reg, m_data_next;

    ptm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_PAGES * 512)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ptm_walk #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_va     (s_tdata[VA_W-1:0]),
        .in_frame  (s_tdata[VA_W+FRAME_W-1:VA_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_data_reg.phys_addr};
    assign m_tuser  = m_data_reg.status;

endmodule

`default_nettype wire

/* sv/ptm_checker.sv */
`default_nettype none

module ptm_checker import ptm_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [87:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // drop valid and ready on the edge after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs not idle after reset");

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken during a walk");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_UNMAPPED
                      || m_tuser == STAT_FULL))
        else $error("undefined status");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata == 56'd0)
        else $error("address set on failed transaction");

endmodule

bind four_level_page_table_manager_unit ptm_checker u_ptm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
